// ===== sv/cyf_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cyf_pkg
// Shared types, constants and the weight table generator for the column
// neighborhood filter.
// ============================================================================
package cyf_pkg;

    localparam int DEF_MAX_WIDTH          = 512;
    localparam int DEF_MAX_HEIGHT         = 512;
    localparam int DEF_MAX_HALF_WINDOW    = 16;
    localparam int DEF_WEIGHT_TABLE_DEPTH = 256;

    localparam logic [63:0] EXP_STEP_Q30 = 64'd1008687096;

    // reset values of the configuration registers
    localparam logic [31:0] RST_NOISE_LIMIT  = 32'd256;
    localparam logic        RST_ADAPTIVE     = 1'b0;
    localparam logic [15:0] RST_NOISE_FLOOR  = 16'd1;
    localparam logic [4:0]  RST_HALF_WINDOW  = 5'd8;
    localparam logic [9:0]  RST_IMAGE_WIDTH  = 10'd512;
    localparam logic [9:0]  RST_IMAGE_HEIGHT = 10'd512;

    // shared multiplier and divider sizes
    localparam int MCD_W  = 96;
    localparam int MPL_W  = 48;
    localparam int MCNT_W = 6;
    localparam int SHQ_W  = 109;
    localparam int DVS_W  = 64;
    localparam int DCNT_W = 7;
    localparam int VAR_SHIFT = 13;

    typedef enum logic [2:0] {
        REG_NOISE_LIMIT  = 3'd0,
        REG_ADAPTIVE     = 3'd1,
        REG_NOISE_FLOOR  = 3'd2,
        REG_HALF_WINDOW  = 3'd3,
        REG_IMAGE_WIDTH  = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5
    } reg_index_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef struct packed {
        logic               opcode;
        logic [8:0]         row;
        logic [8:0]         col;
        logic signed [15:0] pixel_value;
        logic               masked;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] filtered_value;
        logic               passed_through;
        logic [31:0]        noise_in_use;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EST_INIT, S_EST_CRD, S_EST_CD, S_EST_TRD, S_EST_TD, S_EST_TACC, S_EST_NEXT,
        S_VAR_L1, S_VAR_M1, S_VAR_L2, S_VAR_M2, S_VAR_L3, S_VAR_M3,
        S_VAR_CHK, S_VAR_DIV, S_VAR_FIN,
        S_NOISE, S_CEN_RD, S_CEN_D,
        S_TAP_RD, S_TAP_D, S_TAP_SQ, S_TAP_DIV, S_TAP_W, S_TAP_ACC, S_TAP_NEXT,
        S_FIN_LD, S_FIN_DIV, S_FIN_Q, S_OUT
    } state_t;

    // exp(-idx/16) in Q16 from the Q30 recurrence; evaluated at elaboration
    function automatic logic [16:0] exp_weight(input int idx);
        logic [63:0] t;
        t = 64'd1 << 30;
        for (int i = 0; i < idx; i++)
        begin
            t = (t * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
        end
        return 17'((t + 64'd8192) >> 14);
    endfunction

endpackage

// ===== sv/column_yaroslavsky_filter_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// column_yaroslavsky_filter_unit
// Column neighborhood filter over a pixel store: a shared divider, a shift-add
// multiplier and a small signed multiplier under a sequencer.
// ============================================================================
// Input beats on in_valid/in_ready carry a load (write one pixel and its mask
// bit) or a query (filter one pixel). Results leave on out_valid/out_ready,
// one beat per answered query; loads and queries outside the image give none.
// Registers are written through wr_en/wr_index/wr_data; the user writes them
// only while the block idles, which the block itself does not enforce. A load
// leaves the block idle. A query reads the centre pixel and then R window rows
// (up to 2*half_window+1). For each row the bit-serial divider forms the table
// index, an IW-bit quotient with IW = log2 of the weight table depth (8); rows
// whose weight falls off the table skip that divide. A final divide gives the
// mean, with MAG_W the final quotient width (40 with the defaults).
// In adaptive mode the first query after a load first sweeps the image: it
// reads each pixel and the window rows of each unmasked pixel, then runs the
// serial multiplies and the divide for the variance.
// Reset returns the sequencer to idle, clears the estimate and restores the
// register defaults; the pixel store is not cleared. A stalled receiver
// holds the result register; the block then accepts the next beat but waits
// before delivering its result.
// ============================================================================
module column_yaroslavsky_filter_unit #(
    parameter int MAX_WIDTH          = cyf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT         = cyf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_HALF_WINDOW    = cyf_pkg::DEF_MAX_HALF_WINDOW,
    parameter int WEIGHT_TABLE_DEPTH = cyf_pkg::DEF_WEIGHT_TABLE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cyf_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cyf_pkg::out_item_t out_data,
    input  logic              wr_en,
    input  logic [2:0]        wr_index,
    input  logic [31:0]       wr_data
);

    localparam int RIW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CIW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EHW   = $clog2(MAX_HEIGHT + 1);
    localparam int EWW   = $clog2(MAX_WIDTH + 1);
    localparam int HWW   = $clog2(MAX_HALF_WINDOW + 1);
    localparam int RCW   = $clog2(MAX_HEIGHT + MAX_HALF_WINDOW + 1);
    localparam int IW    = $clog2(WEIGHT_TABLE_DEPTH);
    localparam int TAPW  = $clog2(2 * MAX_HALF_WINDOW + 2);
    localparam int DEN_W = 17 + TAPW;
    localparam int NUM_W = 33 + TAPW;
    localparam int TW    = NUM_W + 2;
    localparam int MAG_W = NUM_W + 1;
    localparam int SHQ_W = cyf_pkg::SHQ_W;
    localparam int DVS_W = cyf_pkg::DVS_W;

    // configuration registers
    logic [31:0] limit_reg;
    logic        adapt_reg;
    logic [15:0] floor_reg;
    logic [4:0]  half_reg;
    logic [9:0]  width_reg;
    logic [9:0]  height_reg;

    cyf_pkg::state_t state_reg, state_next;

    logic [16:0] mem [DEPTH];
    logic [16:0] rd_q;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [RIW-1:0] rd_row;
    logic [CIW-1:0] rd_col;

    logic [RIW-1:0] q_row_reg, r_reg, j_reg;
    logic [CIW-1:0] q_col_reg, c_reg;
    logic [15:0]    pc_reg, p_reg;
    logic           est_valid_reg;
    logic [31:0]    v_reg, h_reg;

    logic signed [47:0] dsum_reg;
    logic [63:0]        dsq_reg;
    logic [31:0]        dcnt_reg;

    logic [cyf_pkg::MCD_W-1:0]  mcd_reg, acc_reg, pa_reg, pb_reg;
    logic [cyf_pkg::MPL_W-1:0]  mpl_reg;
    logic [cyf_pkg::MCNT_W-1:0] mcnt_reg;

    logic [SHQ_W-1:0]           shq_reg;
    logic [DVS_W-1:0]           rem_reg, dvs_reg;
    logic [cyf_pkg::DCNT_W-1:0] dvc_reg;
    logic [DVS_W+1:0]           dv_diff;
    logic                       dv_ge;

    logic signed [35:0] prod_reg;
    logic signed [17:0] mul_x, mul_y;
    logic signed [16:0] d_now;

    logic signed [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [16:0]             w_reg, w_now;
    logic                    fneg_reg;
    logic signed [15:0]      res_val_reg;
    logic                    res_pt_reg;

    logic        out_valid_reg;
    cyf_pkg::out_item_t out_data_reg;

    logic [16:0] wlut [WEIGHT_TABLE_DEPTH];

    logic [EHW-1:0] eff_ht;
    logic [EWW-1:0] eff_wd;
    logic [HWW-1:0] hw_eff;
    logic [RIW-1:0] ht_last, win_row, win_lo, win_hi;
    logic [CIW-1:0] wd_last;
    logic [RCW-1:0] win_sum;
    logic [31:0]    floor_eff, h_cand, h_new;
    logic [47:0]    s1abs;
    logic [43:0]    tap_n;
    logic [45:0]    tap_lim;
    logic           tap_in;
    logic signed [TW-1:0] t_sig;
    logic [MAG_W-1:0]     t_mag;
    logic [MAG_W:0]       q_adj;
    logic [cyf_pkg::MCD_W-1:0] var_x;

    logic accept, load_fire, query_ok, out_load;

    for (genvar g = 0; g < WEIGHT_TABLE_DEPTH; g++)
    begin : g_lut
        assign wlut[g] = cyf_pkg::exp_weight(g);
    end

    // ------------------------------------------------------------------
    // effective configuration and window bounds
    // ------------------------------------------------------------------
    always_comb
    begin
        if (height_reg == '0)
            eff_ht = EHW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            eff_ht = EHW'(MAX_HEIGHT);
        else
            eff_ht = EHW'(height_reg);
        if (width_reg == '0)
            eff_wd = EWW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            eff_wd = EWW'(MAX_WIDTH);
        else
            eff_wd = EWW'(width_reg);
        if (32'(half_reg) > MAX_HALF_WINDOW)
            hw_eff = HWW'(MAX_HALF_WINDOW);
        else
            hw_eff = HWW'(half_reg);
    end

    assign ht_last = RIW'(eff_ht - EHW'(1));
    assign wd_last = CIW'(eff_wd - EWW'(1));

    assign win_row = (state_reg == cyf_pkg::S_EST_CD || state_reg == cyf_pkg::S_EST_TACC)
                     ? r_reg : q_row_reg;
    assign win_sum = RCW'(win_row) + RCW'(hw_eff);

    always_comb
    begin
        if (RCW'(win_row) > RCW'(hw_eff))
            win_lo = RIW'(RCW'(win_row) - RCW'(hw_eff));
        else
            win_lo = '0;
        if (win_sum > RCW'(ht_last))
            win_hi = ht_last;
        else
            win_hi = RIW'(win_sum);
    end

    assign floor_eff = (floor_reg == '0) ? 32'd1 : 32'(floor_reg);
    assign h_cand    = (adapt_reg && v_reg < limit_reg) ? v_reg : limit_reg;
    assign h_new     = (h_cand < floor_eff) ? floor_eff : h_cand;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign in_ready  = (state_reg == cyf_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign load_fire = accept && in_data.opcode == cyf_pkg::OP_LOAD
                       && 32'(in_data.row) < MAX_HEIGHT && 32'(in_data.col) < MAX_WIDTH;
    assign query_ok  = 32'(in_data.row) < 32'(eff_ht) && 32'(in_data.col) < 32'(eff_wd);
    assign out_load  = (state_reg == cyf_pkg::S_OUT) && (!out_valid_reg || out_ready);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= cyf_pkg::RST_NOISE_LIMIT;
            adapt_reg  <= cyf_pkg::RST_ADAPTIVE;
            floor_reg  <= cyf_pkg::RST_NOISE_FLOOR;
            half_reg   <= cyf_pkg::RST_HALF_WINDOW;
            width_reg  <= cyf_pkg::RST_IMAGE_WIDTH;
            height_reg <= cyf_pkg::RST_IMAGE_HEIGHT;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                cyf_pkg::REG_NOISE_LIMIT:  limit_reg  <= wr_data;
                cyf_pkg::REG_ADAPTIVE:     adapt_reg  <= wr_data[0];
                cyf_pkg::REG_NOISE_FLOOR:  floor_reg  <= wr_data[15:0];
                cyf_pkg::REG_HALF_WINDOW:  half_reg   <= wr_data[4:0];
                cyf_pkg::REG_IMAGE_WIDTH:  width_reg  <= wr_data[9:0];
                cyf_pkg::REG_IMAGE_HEIGHT: height_reg <= wr_data[9:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pixel store
    // ------------------------------------------------------------------
    assign wr_addr = AW'(AW'(RIW'(in_data.row)) * AW'(MAX_WIDTH) + AW'(CIW'(in_data.col)));

    always_comb
    begin
        case (state_reg)
            cyf_pkg::S_EST_CRD: begin rd_row = r_reg;     rd_col = c_reg;     end
            cyf_pkg::S_EST_TRD: begin rd_row = j_reg;     rd_col = c_reg;     end
            cyf_pkg::S_CEN_RD:  begin rd_row = q_row_reg; rd_col = q_col_reg; end
            default:            begin rd_row = j_reg;     rd_col = q_col_reg; end
        endcase
    end

    assign rd_addr = AW'(AW'(rd_row) * AW'(MAX_WIDTH) + AW'(rd_col));

    always_ff @(posedge clk)
    begin
        if (load_fire)
            mem[wr_addr] <= {in_data.masked, in_data.pixel_value};
    end

    always_ff @(posedge clk)
    begin
        rd_q <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // small signed multiplier, registered
    // ------------------------------------------------------------------
    assign d_now = $signed({rd_q[15], rd_q[15:0]}) - $signed({pc_reg[15], pc_reg});
    assign w_now = wlut[shq_reg[IW-1:0]];

    always_comb
    begin
        if (state_reg == cyf_pkg::S_TAP_W)
        begin
            mul_x = $signed({1'b0, w_now});
            mul_y = $signed({{2{p_reg[15]}}, p_reg});
        end
        else
        begin
            mul_x = $signed({d_now[16], d_now});
            mul_y = $signed({d_now[16], d_now});
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_x * mul_y;
    end

    // ------------------------------------------------------------------
    // shared datapath terms
    // ------------------------------------------------------------------
    assign dv_diff = {1'b0, rem_reg, shq_reg[SHQ_W-1]} - {2'b00, dvs_reg};
    assign dv_ge   = !dv_diff[DVS_W+1];

    assign s1abs   = dsum_reg[47] ? 48'(-dsum_reg) : 48'(dsum_reg);
    assign tap_n   = {prod_reg[31:0], 12'b0};
    assign tap_lim = 46'(h_reg) * 46'(WEIGHT_TABLE_DEPTH);
    assign tap_in  = 46'(tap_n) < tap_lim;
    assign var_x   = pa_reg - pb_reg;

    assign t_sig = $signed({num_reg[NUM_W-1], num_reg, 1'b0})
                 + $signed({{(TW-DEN_W){1'b0}}, den_reg});
    assign t_mag = t_sig[TW-1] ? MAG_W'(-t_sig) : MAG_W'(t_sig);
    assign q_adj = (MAG_W+1)'(shq_reg[MAG_W-1:0])
                 + (MAG_W+1)'(fneg_reg && rem_reg != '0);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cyf_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cyf_pkg::S_IDLE:
            begin
                if (accept && in_data.opcode == cyf_pkg::OP_QUERY && query_ok)
                    state_next = (adapt_reg && !est_valid_reg) ? cyf_pkg::S_EST_INIT
                                                                : cyf_pkg::S_NOISE;
            end
            cyf_pkg::S_EST_INIT: state_next = cyf_pkg::S_EST_CRD;
            cyf_pkg::S_EST_CRD:  state_next = cyf_pkg::S_EST_CD;
            cyf_pkg::S_EST_CD:
                state_next = rd_q[16] ? cyf_pkg::S_EST_NEXT : cyf_pkg::S_EST_TRD;
            cyf_pkg::S_EST_TRD:  state_next = cyf_pkg::S_EST_TD;
            cyf_pkg::S_EST_TD:   state_next = cyf_pkg::S_EST_TACC;
            cyf_pkg::S_EST_TACC:
                state_next = (j_reg == win_hi) ? cyf_pkg::S_EST_NEXT : cyf_pkg::S_EST_TRD;
            cyf_pkg::S_EST_NEXT:
                state_next = (c_reg == wd_last && r_reg == ht_last) ? cyf_pkg::S_VAR_L1
                                                                    : cyf_pkg::S_EST_CRD;
            cyf_pkg::S_VAR_L1:   state_next = cyf_pkg::S_VAR_M1;
            cyf_pkg::S_VAR_M1:
                if (mcnt_reg == '0) state_next = cyf_pkg::S_VAR_L2;
            cyf_pkg::S_VAR_L2:   state_next = cyf_pkg::S_VAR_M2;
            cyf_pkg::S_VAR_M2:
                if (mcnt_reg == '0) state_next = cyf_pkg::S_VAR_L3;
            cyf_pkg::S_VAR_L3:   state_next = cyf_pkg::S_VAR_M3;
            cyf_pkg::S_VAR_M3:
                if (mcnt_reg == '0) state_next = cyf_pkg::S_VAR_CHK;
            cyf_pkg::S_VAR_CHK:
                state_next = (dcnt_reg == '0 || pa_reg < pb_reg) ? cyf_pkg::S_NOISE
                                                                 : cyf_pkg::S_VAR_DIV;
            cyf_pkg::S_VAR_DIV:
                if (dvc_reg == '0) state_next = cyf_pkg::S_VAR_FIN;
            cyf_pkg::S_VAR_FIN:  state_next = cyf_pkg::S_NOISE;
            cyf_pkg::S_NOISE:    state_next = cyf_pkg::S_CEN_RD;
            cyf_pkg::S_CEN_RD:   state_next = cyf_pkg::S_CEN_D;
            cyf_pkg::S_CEN_D:
                state_next = rd_q[16] ? cyf_pkg::S_OUT : cyf_pkg::S_TAP_RD;
            cyf_pkg::S_TAP_RD:   state_next = cyf_pkg::S_TAP_D;
            cyf_pkg::S_TAP_D:    state_next = cyf_pkg::S_TAP_SQ;
            cyf_pkg::S_TAP_SQ:
                state_next = tap_in ? cyf_pkg::S_TAP_DIV : cyf_pkg::S_TAP_NEXT;
            cyf_pkg::S_TAP_DIV:
                if (dvc_reg == '0) state_next = cyf_pkg::S_TAP_W;
            cyf_pkg::S_TAP_W:    state_next = cyf_pkg::S_TAP_ACC;
            cyf_pkg::S_TAP_ACC:  state_next = cyf_pkg::S_TAP_NEXT;
            cyf_pkg::S_TAP_NEXT:
                state_next = (j_reg == win_hi) ? cyf_pkg::S_FIN_LD : cyf_pkg::S_TAP_RD;
            cyf_pkg::S_FIN_LD:   state_next = cyf_pkg::S_FIN_DIV;
            cyf_pkg::S_FIN_DIV:
                if (dvc_reg == '0) state_next = cyf_pkg::S_FIN_Q;
            cyf_pkg::S_FIN_Q:    state_next = cyf_pkg::S_OUT;
            cyf_pkg::S_OUT:
                if (out_load) state_next = cyf_pkg::S_IDLE;
            default:             state_next = cyf_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_fire)
                est_valid_reg <= 1'b0;
            else if (state_reg == cyf_pkg::S_EST_NEXT && state_next == cyf_pkg::S_VAR_L1)
                est_valid_reg <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.filtered_value <= res_val_reg;
            out_data_reg.passed_through <= res_pt_reg;
            out_data_reg.noise_in_use   <= h_reg;
        end

        // divider step, shared by the table index, variance and final mean
        if ((state_reg == cyf_pkg::S_TAP_DIV || state_reg == cyf_pkg::S_VAR_DIV
             || state_reg == cyf_pkg::S_FIN_DIV) && dvc_reg != '0)
        begin
            rem_reg <= dv_ge ? dv_diff[DVS_W-1:0] : {rem_reg[DVS_W-2:0], shq_reg[SHQ_W-1]};
            shq_reg <= {shq_reg[SHQ_W-2:0], dv_ge};
            dvc_reg <= dvc_reg - 1'b1;
        end

        // shift-add multiplier step
        if ((state_reg == cyf_pkg::S_VAR_M1 || state_reg == cyf_pkg::S_VAR_M2
             || state_reg == cyf_pkg::S_VAR_M3) && mcnt_reg != '0)
        begin
            if (mpl_reg[0])
                acc_reg <= acc_reg + mcd_reg;
            mcd_reg  <= {mcd_reg[cyf_pkg::MCD_W-2:0], 1'b0};
            mpl_reg  <= {1'b0, mpl_reg[cyf_pkg::MPL_W-1:1]};
            mcnt_reg <= mcnt_reg - 1'b1;
        end

        case (state_reg)
            cyf_pkg::S_IDLE:
            begin
                q_row_reg <= RIW'(in_data.row);
                q_col_reg <= CIW'(in_data.col);
            end
            cyf_pkg::S_EST_INIT:
            begin
                r_reg    <= '0;
                c_reg    <= '0;
                dsum_reg <= '0;
                dsq_reg  <= '0;
                dcnt_reg <= '0;
            end
            cyf_pkg::S_EST_CD:
            begin
                pc_reg <= rd_q[15:0];
                j_reg  <= win_lo;
            end
            cyf_pkg::S_EST_TD:
                dsum_reg <= dsum_reg + 48'(d_now);
            cyf_pkg::S_EST_TACC:
            begin
                dsq_reg  <= dsq_reg + 64'(prod_reg[31:0]);
                dcnt_reg <= dcnt_reg + 32'd1;
                j_reg    <= j_reg + 1'b1;
            end
            cyf_pkg::S_EST_NEXT:
            begin
                // advance column, then row
                if (c_reg == wd_last)
                begin
                    c_reg <= '0;
                    r_reg <= r_reg + 1'b1;
                end
                else
                    c_reg <= c_reg + 1'b1;
            end
            cyf_pkg::S_VAR_L1:
            begin
                mpl_reg  <= cyf_pkg::MPL_W'(dcnt_reg);
                mcd_reg  <= cyf_pkg::MCD_W'(dsq_reg);
                acc_reg  <= '0;
                mcnt_reg <= cyf_pkg::MCNT_W'(32);
            end
            cyf_pkg::S_VAR_L2:
            begin
                pa_reg   <= acc_reg;
                mpl_reg  <= s1abs;
                mcd_reg  <= cyf_pkg::MCD_W'(s1abs);
                acc_reg  <= '0;
                mcnt_reg <= cyf_pkg::MCNT_W'(48);
            end
            cyf_pkg::S_VAR_L3:
            begin
                pb_reg   <= acc_reg;
                mpl_reg  <= cyf_pkg::MPL_W'(dcnt_reg);
                mcd_reg  <= cyf_pkg::MCD_W'(dcnt_reg);
                acc_reg  <= '0;
                mcnt_reg <= cyf_pkg::MCNT_W'(32);
            end
            cyf_pkg::S_VAR_CHK:
            begin
                v_reg   <= '0;
                shq_reg <= {var_x, {cyf_pkg::VAR_SHIFT{1'b0}}};
                rem_reg <= '0;
                dvs_reg <= acc_reg[DVS_W-1:0];
                dvc_reg <= cyf_pkg::DCNT_W'(SHQ_W);
            end
            cyf_pkg::S_VAR_FIN:
                v_reg <= (|shq_reg[SHQ_W-1:32]) ? 32'hFFFF_FFFF : shq_reg[31:0];
            cyf_pkg::S_NOISE:
                h_reg <= h_new;
            cyf_pkg::S_CEN_D:
            begin
                pc_reg      <= rd_q[15:0];
                j_reg       <= win_lo;
                num_reg     <= '0;
                den_reg     <= '0;
                res_val_reg <= $signed(rd_q[15:0]);
                res_pt_reg  <= rd_q[16];
            end
            cyf_pkg::S_TAP_D:
                p_reg <= rd_q[15:0];
            cyf_pkg::S_TAP_SQ:
            begin
                rem_reg <= DVS_W'(tap_n >> IW);
                shq_reg <= {tap_n[IW-1:0], {(SHQ_W-IW){1'b0}}};
                dvs_reg <= DVS_W'(h_reg);
                dvc_reg <= cyf_pkg::DCNT_W'(IW);
            end
            cyf_pkg::S_TAP_W:
                w_reg <= w_now;
            cyf_pkg::S_TAP_ACC:
            begin
                num_reg <= num_reg + NUM_W'(prod_reg);
                den_reg <= den_reg + DEN_W'(w_reg);
            end
            cyf_pkg::S_TAP_NEXT:
                j_reg <= j_reg + 1'b1;
            cyf_pkg::S_FIN_LD:
            begin
                fneg_reg <= t_sig[TW-1];
                shq_reg  <= {t_mag, {(SHQ_W-MAG_W){1'b0}}};
                rem_reg  <= '0;
                dvs_reg  <= DVS_W'({den_reg, 1'b0});
                dvc_reg  <= cyf_pkg::DCNT_W'(MAG_W);
            end
            cyf_pkg::S_FIN_Q:
            begin
                // floor toward minus infinity, then clamp to the sample range
                if (fneg_reg)
                    res_val_reg <= (q_adj > (MAG_W+1)'(32768)) ? -16'sd32768
                                                               : $signed(16'(-q_adj));
                else
                    res_val_reg <= (q_adj > (MAG_W+1)'(32767)) ? 16'sd32767
                                                               : $signed(q_adj[15:0]);
                res_pt_reg <= 1'b0;
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/cyf_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cyf_checker
// Port-level checks for the column neighborhood filter, bound to the top.
// ============================================================================
module cyf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input cyf_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input cyf_pkg::out_item_t out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_noise_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.noise_in_use != 32'd0)
        else $error("noise in use is zero");

    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.opcode == cyf_pkg::OP_LOAD |=> in_ready)
        else $error("load beat held the input side");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid && in_data.opcode == cyf_pkg::OP_QUERY))
        else $error("input side went busy without a query");

endmodule

bind column_yaroslavsky_filter_unit cyf_checker u_cyf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for column_yaroslavsky_filter_unit: random and directed
// load/query beats over several register settings, a scoreboard that
// predicts each filtered pixel and compares every result beat.
// ============================================================================
module tb;

    class column_mean_board;
        logic [16:0] img [0:262143];
        bit          loaded [0:262143];
        logic [16:0] exp_weight_q16 [0:255];
        cyf_pkg::out_item_t expected_pixels [$];
        bit          estimate_ok;
        longint      diff_total;
        logic [63:0] diff_sq_total;
        logic [31:0] diff_n;
        logic [31:0] limit_r;
        logic        adapt_r;
        logic [15:0] floor_r;
        logic [4:0]  half_r;
        logic [9:0]  width_r;
        logic [9:0]  height_r;
        int          errors;

        function new();
            logic [63:0] t;
            t = 64'd1 << 30;
            for (int i = 0; i < 256; i++)
            begin
                exp_weight_q16[i] = 17'((t + 64'd8192) >> 14);
                t = (t * 64'd1008687096 + (64'd1 << 29)) >> 30;
            end
            limit_r = 32'd256;
            adapt_r = 1'b0;
            floor_r = 16'd1;
            half_r = 5'd8;
            width_r = 10'd512;
            height_r = 10'd512;
        endfunction

        function void set_reg(cyf_pkg::reg_index_t idx, logic [31:0] v);
            case (idx)
                cyf_pkg::REG_NOISE_LIMIT:  limit_r = v;
                cyf_pkg::REG_ADAPTIVE:     adapt_r = v[0];
                cyf_pkg::REG_NOISE_FLOOR:  floor_r = v[15:0];
                cyf_pkg::REG_HALF_WINDOW:  half_r = v[4:0];
                cyf_pkg::REG_IMAGE_WIDTH:  width_r = v[9:0];
                cyf_pkg::REG_IMAGE_HEIGHT: height_r = v[9:0];
                default: ;
            endcase
        endfunction

        function int eff_w();
            return width_r == 0 ? 1 : (width_r > 512 ? 512 : int'(width_r));
        endfunction
        function int eff_h();
            return height_r == 0 ? 1 : (height_r > 512 ? 512 : int'(height_r));
        endfunction
        function int eff_half();
            return half_r > 16 ? 16 : int'(half_r);
        endfunction

        function longint px(int r, int c);
            return longint'($signed(img[r * 512 + c][15:0]));
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // true when a query here reads only entries already loaded
        function bit query_safe(int r, int c);
            int ht, lo, hi;
            ht = eff_h();
            if (r >= ht || c >= eff_w())
                return 1;
            if (adapt_r && !estimate_ok)
            begin
                for (int i = 0; i < ht; i++)
                    for (int k = 0; k < eff_w(); k++)
                        if (!loaded[i * 512 + k])
                            return 0;
            end
            lo = r > eff_half() ? r - eff_half() : 0;
            hi = r + eff_half() > ht - 1 ? ht - 1 : r + eff_half();
            for (int j = lo; j <= hi; j++)
                if (!loaded[j * 512 + c])
                    return 0;
            return 1;
        endfunction

        function void gather_differences();
            int ht, hw, lo, hi;
            longint d;
            ht = eff_h();
            hw = eff_half();
            diff_total = 0;
            diff_sq_total = 0;
            diff_n = 0;
            for (int r = 0; r < ht; r++)
            begin
                lo = r > hw ? r - hw : 0;
                hi = r + hw > ht - 1 ? ht - 1 : r + hw;
                for (int c = 0; c < eff_w(); c++)
                begin
                    if (img[r * 512 + c][16])
                        continue;
                    for (int j = lo; j <= hi; j++)
                    begin
                        d = px(j, c) - px(r, c);
                        diff_total += d;
                        diff_sq_total += 64'(d * d);
                        diff_n++;
                    end
                end
            end
            estimate_ok = 1;
        endfunction

        function logic [31:0] noise_h();
            logic [63:0]  h, v, s1;
            logic [127:0] a, b, nn;
            logic [31:0]  fl;
            h = 64'(limit_r);
            fl = floor_r == 0 ? 32'd1 : 32'(floor_r);
            if (adapt_r)
            begin
                v = 0;
                if (diff_n != 0)
                begin
                    s1 = diff_total < 0 ? 64'(-diff_total) : 64'(diff_total);
                    a = 128'(diff_n) * 128'(diff_sq_total);
                    b = 128'(s1) * 128'(s1);
                    if (a >= b)
                    begin
                        nn = (a - b) << 13;
                        nn = nn / 128'(diff_n);
                        nn = nn / 128'(diff_n);
                        v = nn > 128'hFFFFFFFF ? 64'hFFFFFFFF : nn[63:0];
                    end
                end
                if (v < h)
                    h = v;
            end
            if (h < 64'(fl))
                h = 64'(fl);
            return h[31:0];
        endfunction

        function void note_beat(cyf_pkg::in_item_t x);
            int r, c, ht, hw, lo, hi;
            longint pc, p, d, idx, num, den, t, dv, q;
            logic [31:0] h;
            cyf_pkg::out_item_t e;
            r = x.row;
            c = x.col;
            if (x.opcode == cyf_pkg::OP_LOAD)
            begin
                img[r * 512 + c] = {x.masked, x.pixel_value};
                loaded[r * 512 + c] = 1;
                estimate_ok = 0;
                return;
            end
            ht = eff_h();
            if (r >= ht || c >= eff_w())
                return;
            if (adapt_r && !estimate_ok)
                gather_differences();
            h = noise_h();
            pc = px(r, c);
            e.noise_in_use = h;
            if (img[r * 512 + c][16])
            begin
                e.filtered_value = 16'(pc);
                e.passed_through = 1'b1;
                expected_pixels.push_back(e);
                return;
            end
            hw = eff_half();
            lo = r > hw ? r - hw : 0;
            hi = r + hw > ht - 1 ? ht - 1 : r + hw;
            num = 0;
            den = 0;
            for (int j = lo; j <= hi; j++)
            begin
                p = px(j, c);
                d = p - pc;
                idx = (d * d * 4096) / longint'(h);
                if (idx < 256)
                begin
                    num += longint'(exp_weight_q16[idx]) * p;
                    den += longint'(exp_weight_q16[idx]);
                end
            end
            t = 2 * num + den;
            dv = 2 * den;
            q = t >= 0 ? t / dv : -((-t + dv - 1) / dv);
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            e.filtered_value = 16'(q);
            e.passed_through = 1'b0;
            expected_pixels.push_back(e);
        endfunction

        function void check_beat(cyf_pkg::out_item_t got);
            cyf_pkg::out_item_t e;
            if (expected_pixels.size() == 0)
            begin
                $error("result beat with nothing expected: %0d %0d %0d",
                       got.filtered_value, got.passed_through, got.noise_in_use);
                errors++;
                return;
            end
            e = expected_pixels.pop_front();
            if (got.filtered_value !== e.filtered_value)
            begin
                $error("filtered_value expected %0d actual %0d",
                       e.filtered_value, got.filtered_value);
                errors++;
            end
            if (got.passed_through !== e.passed_through)
            begin
                $error("passed_through expected %0d actual %0d",
                       e.passed_through, got.passed_through);
                errors++;
            end
            if (got.noise_in_use !== e.noise_in_use)
            begin
                $error("noise_in_use expected %0d actual %0d",
                       e.noise_in_use, got.noise_in_use);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    cyf_pkg::in_item_t  in_data;
    logic        out_valid;
    logic        out_ready;
    cyf_pkg::out_item_t out_data;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [31:0] wr_data;

    column_mean_board board = new();
    bit  calm;
    int  hold_left;
    int  base_val, spread;
    int  r0, c0, rw, rh;

    column_yaroslavsky_filter_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #400_000_000;
        $display("column_yaroslavsky_filter_unit regression: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_beat(in_data);
            if (out_valid && out_ready)
                board.check_beat(out_data);
        end
    end

    // result side: random backpressure, or a long hold when asked
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    task automatic send(cyf_pkg::in_item_t x);
        if (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_value();
        int v;
        int r;
        r = $urandom_range(99);
        if (r < 5)
            v = $urandom_range(1) ? 32767 : -32768;
        else if (r < 15)
            v = int'($signed(16'($urandom)));
        else
            v = base_val + int'($urandom_range(2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    task automatic send_load(int r, int c);
        cyf_pkg::in_item_t x;
        x.opcode = cyf_pkg::OP_LOAD;
        x.row = 9'(r);
        x.col = 9'(c);
        x.pixel_value = pick_value();
        x.masked = $urandom_range(99) < 10;
        send(x);
    endtask

    // a query that would read an unloaded entry becomes a load there
    task automatic send_query(int r, int c);
        cyf_pkg::in_item_t x;
        if (!board.query_safe(r, c))
            send_load(r, c);
        else
        begin
            x.opcode = cyf_pkg::OP_QUERY;
            x.row = 9'(r);
            x.col = 9'(c);
            x.pixel_value = 16'($urandom);
            x.masked = $urandom_range(1);
            send(x);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        // let a clock edge pass so the last accepted beat is noted
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_regs(logic [31:0] lim, logic ad, logic [15:0] fl,
                              logic [4:0] hw, logic [9:0] w, logic [9:0] h);
        logic [31:0] vals [6];
        vals = '{lim, 32'(ad), 32'(fl), 32'(hw), 32'(w), 32'(h)};
        for (int i = 0; i < 6; i++)
        begin
            wr_en <= 1'b1;
            wr_index <= 3'(i);
            wr_data <= vals[i];
            board.set_reg(cyf_pkg::reg_index_t'(i), vals[i]);
            @(posedge clk);
        end
        wr_en <= 1'b0;
    endtask

    task automatic run_phase(int n);
        int ht, wd, lo, hi, k, r, c;
        ht = board.eff_h();
        wd = board.eff_w();
        lo = r0 > board.eff_half() ? r0 - board.eff_half() : 0;
        hi = r0 + rh - 1 + board.eff_half();
        if (hi > ht - 1)
            hi = ht - 1;
        for (int i = lo; i <= hi; i++)
            for (int j = c0; j < c0 + rw; j++)
                send_load(i, j);
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            r = r0 + $urandom_range(rh - 1);
            c = c0 + $urandom_range(rw - 1);
            if (k < 50)
                send_query(r, c);
            else if (k < 85)
                send_load(r, c);
            else if (k < 90)
            begin
                if (ht < 512)
                    send_query($urandom_range(511, ht), $urandom_range(511));
                else if (wd < 512)
                    send_query($urandom_range(511), $urandom_range(511, wd));
                else
                    send_query(r, c);
            end
            else if (k < 95)
                send_load($urandom_range(511), $urandom_range(511));
            else
                send_query($urandom_range(511), $urandom_range(511));
        end
        drain();
    endtask

    task automatic setup(int p);
        int lim, ad, fl, hw, w, h;
        r0 = 0;
        c0 = 0;
        spread = 64;
        base_val = $urandom_range(20000) - 10000;
        case (p)
            0: begin lim = 256;        ad = 0; fl = 1;     hw = 8;  w = 512;  h = 512;
                     r0 = 490; c0 = 500; rw = 3; rh = 6; end
            1: begin lim = 0;          ad = 0; fl = 0;     hw = 3;  w = 20;   h = 16;
                     rw = 4; rh = 16; end
            2: begin lim = 'hFFFFFFFF; ad = 0; fl = 65535; hw = 16; w = 3;    h = 40;
                     r0 = 10; rw = 3; rh = 8; spread = 2000; end
            3: begin lim = 5000;       ad = 1; fl = 1;     hw = 4;  w = 4;    h = 12; end
            4: begin lim = 'hFFFFFFFF; ad = 1; fl = 1;     hw = 2;  w = 3;    h = 10;
                     spread = 30000; base_val = 0; end
            5: begin lim = 1000;       ad = 0; fl = 200;   hw = 31; w = 0;    h = 40;
                     r0 = 5; rw = 1; rh = 10; end
            6: begin lim = 65536;      ad = 1; fl = 65535; hw = 0;  w = 2;    h = 8; end
            7: begin lim = 300;        ad = 0; fl = 1;     hw = 1;  w = 1023; h = 1023;
                     r0 = 250; c0 = 256; rw = 2; rh = 8; spread = 16; end
            8: begin lim = 20;         ad = 1; fl = 3;     hw = 6;  w = 5;    h = 9; end
            default: begin lim = 12345678; ad = 0; fl = 7; hw = 5;  w = 100;  h = 30;
                     r0 = 20; c0 = 97; rw = 3; rh = 10; spread = 500; end
        endcase
        write_regs(lim, ad, fl, hw, w, h);
        if (ad)
        begin
            rw = board.eff_w();
            rh = board.eff_h();
        end
    endtask

    initial
    begin
        cyf_pkg::in_item_t x;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        wr_en <= 1'b0;
        wr_index <= cyf_pkg::REG_NOISE_LIMIT;
        wr_data <= '0;
        calm = 0;
        hold_left = 0;
        base_val = 0;
        spread = 64;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extreme samples at the top left corner, random ones at the bottom right corner
        for (int i = 0; i <= 8; i++)
        begin
            x.opcode = cyf_pkg::OP_LOAD;
            x.row = 9'(i);
            x.col = 9'd0;
            x.pixel_value = (i % 2) ? -16'sd32768 : 16'sd32767;
            if (i > 4)
                x.pixel_value = 16'(i * 3 - 10);
            x.masked = i == 3;
            send(x);
        end
        for (int i = 503; i <= 511; i++)
            send_load(i, 511);
        send_query(0, 0);
        send_query(3, 0);
        send_query(6, 0);
        send_query(511, 511);
        send_query(507, 511);
        drain();

        for (int p = 0; p < 10; p++)
        begin
            setup(p);
            calm = p == 1;
            if (p == 0)
                hold_left = 800;
            run_phase(p == 3 || p == 7 || p == 8 || p == 9 ? 150 : 120);
        end
        calm = 0;
        drain();

        if (board.errors == 0 && board.pending() == 0)
            $display("column_yaroslavsky_filter_unit regression: pass");
        else
            $display("column_yaroslavsky_filter_unit regression: fail");
        $finish;
    end
endmodule
